// ===== rtl/tccw_pkg.sv =====
// Shared types and constants of the text console character writer.
package tccw_pkg;

    // Opcodes carried in the op field of an input word
    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    localparam logic [7:0]  CH_NEWLINE  = 8'h0A;
    localparam logic [7:0]  CH_BLANK    = 8'h20;
    localparam logic [7:0]  RESET_COLOR = 8'h0F;
    localparam logic [15:0] RESET_CELL  = {RESET_COLOR, CH_BLANK};

    localparam int unsigned OP_W   = 2;
    localparam int unsigned CH_W   = 8;
    localparam int unsigned RADDR_W = 11;
    localparam int unsigned POS_W  = 11;
    localparam int unsigned CELL_W = 16;
    localparam int unsigned IN_TDATA_W  = 24;
    localparam int unsigned OUT_TDATA_W = 32;

    localparam int unsigned Q_PTR_W = 1;
    localparam int unsigned Q_DEPTH = 2 ** Q_PTR_W;

    typedef enum logic [2:0] {
        KIND_PUT,
        KIND_NEWLINE,
        KIND_CLEAR,
        KIND_READ,
        KIND_NOP
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [CH_W-1:0]    ch;
        logic [RADDR_W-1:0] addr;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_EXEC,
        ST_SCROLL,
        ST_CLEAR,
        ST_READ
    } t_bstate;

endpackage

// ===== rtl/tccw_front.sv =====
// Front end: accept input words and classify them into commands.
module tccw_front #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [tccw_pkg::IN_TDATA_W-1:0]    i_data,
    input  logic                               i_init_busy,
    input  logic                               i_q_full,
    output logic                               o_push,
    output tccw_pkg::t_cmd                     o_cmd
);

    localparam int unsigned CELLS = COLS * ROWS;

    logic [tccw_pkg::OP_W-1:0]    in_op;
    logic [tccw_pkg::CH_W-1:0]    in_ch;
    logic [tccw_pkg::RADDR_W-1:0] in_addr;

    assign in_op   = i_data[1:0];
    assign in_ch   = i_data[9:2];
    assign in_addr = i_data[20:10];

    // Hold off while the screen is being swept after reset
    assign o_ready = !i_q_full && !i_init_busy;
    assign o_push  = i_valid && o_ready;

    always_comb begin
        o_cmd.ch   = in_ch;
        o_cmd.addr = in_addr;
        unique case (in_op)
            tccw_pkg::OP_PUT: begin
                o_cmd.kind = (in_ch == tccw_pkg::CH_NEWLINE) ? tccw_pkg::KIND_NEWLINE
                                                             : tccw_pkg::KIND_PUT;
            end
            tccw_pkg::OP_CLEAR: begin
                o_cmd.kind = tccw_pkg::KIND_CLEAR;
            end
            tccw_pkg::OP_READ: begin
                o_cmd.kind = (32'(in_addr) < 32'(CELLS)) ? tccw_pkg::KIND_READ
                                                         : tccw_pkg::KIND_NOP;
            end
            default: begin
                o_cmd.kind = tccw_pkg::KIND_NOP;
            end
        endcase
    end

endmodule

// ===== rtl/tccw_queue.sv =====
// Short command queue between front end and back end.
module tccw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  tccw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output tccw_pkg::t_cmd o_cmd
);

    tccw_pkg::t_cmd                r_data [tccw_pkg::Q_DEPTH];
    logic [tccw_pkg::Q_PTR_W-1:0] r_wr_ptr;
    logic [tccw_pkg::Q_PTR_W-1:0] r_rd_ptr;
    logic [tccw_pkg::Q_PTR_W:0]   r_count;
    logic [tccw_pkg::Q_PTR_W-1:0] n_wr_ptr;
    logic [tccw_pkg::Q_PTR_W-1:0] n_rd_ptr;
    logic [tccw_pkg::Q_PTR_W:0]   n_count;

    assign o_full  = (r_count == (tccw_pkg::Q_PTR_W+1)'(tccw_pkg::Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_data[r_rd_ptr];

    always_comb begin
        n_wr_ptr = i_push ? r_wr_ptr + 1'b1 : r_wr_ptr;
        n_rd_ptr = i_pop  ? r_rd_ptr + 1'b1 : r_rd_ptr;
        n_count  = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

// ===== rtl/tccw_back.sv =====
// Back end: screen memory, cursor, scroll and clear sequencer, result register.
module tccw_back #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [7:0]                        i_text_color,
    input  logic                              i_q_empty,
    input  tccw_pkg::t_cmd                    i_q_cmd,
    output logic                              o_pop,
    output logic                              o_init_busy,
    output logic                              o_valid,
    input  logic                              i_ready,
    output logic [tccw_pkg::POS_W-1:0]        o_cursor_pos,
    output logic [tccw_pkg::CELL_W-1:0]       o_cell_data
);

    localparam int unsigned CELLS  = COLS * ROWS;
    localparam int unsigned MOVE   = CELLS - COLS;
    localparam int unsigned ADDR_W = $clog2(CELLS);
    localparam int unsigned CNT_W  = $clog2(CELLS + 1);
    localparam int unsigned ROW_W  = $clog2(ROWS + 1);
    localparam int unsigned COL_W  = $clog2(COLS);

    tccw_pkg::t_bstate r_state, n_state;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic [ROW_W-1:0]  r_row, n_row;
    logic [COL_W-1:0]  r_col, n_col;
    logic [CNT_W-1:0]  r_lin, n_lin;
    tccw_pkg::t_cmd    r_cmd, n_cmd;
    logic              r_out_valid, n_out_valid;
    logic [tccw_pkg::POS_W-1:0]  r_out_pos, n_out_pos;
    logic [tccw_pkg::CELL_W-1:0] r_out_cell, n_out_cell;

    logic [tccw_pkg::CELL_W-1:0] mem [CELLS];
    logic [tccw_pkg::CELL_W-1:0] r_rd_data;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_wa;
    logic [tccw_pkg::CELL_W-1:0] mem_wd;
    logic [ADDR_W-1:0]           mem_ra;

    logic                        out_free;
    logic [CNT_W-1:0]            idx_m1;
    logic [CNT_W-1:0]            rd_src;
    logic [tccw_pkg::CELL_W-1:0] blank;

    assign out_free     = !r_out_valid || i_ready;
    assign idx_m1       = r_idx - CNT_W'(1);
    assign rd_src       = r_idx + CNT_W'(COLS);
    assign blank        = {i_text_color, tccw_pkg::CH_BLANK};
    assign o_init_busy  = (r_state == tccw_pkg::ST_INIT);
    assign o_valid      = r_out_valid;
    assign o_cursor_pos = r_out_pos;
    assign o_cell_data  = r_out_cell;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_row       = r_row;
        n_col       = r_col;
        n_lin       = r_lin;
        n_cmd       = r_cmd;
        n_out_valid = r_out_valid && !i_ready;
        n_out_pos   = r_out_pos;
        n_out_cell  = r_out_cell;
        o_pop       = 1'b0;
        mem_we      = 1'b0;
        mem_wa      = r_idx[ADDR_W-1:0];
        mem_wd      = blank;
        mem_ra      = ADDR_W'(r_cmd.addr);

        unique case (r_state)
            tccw_pkg::ST_INIT: begin
                mem_we = 1'b1;
                mem_wd = tccw_pkg::RESET_CELL;
                n_idx  = r_idx + 1'b1;
                if (r_idx == CNT_W'(CELLS - 1)) begin
                    n_idx   = '0;
                    n_state = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_IDLE: begin
                if (!i_q_empty && out_free) begin
                    o_pop   = 1'b1;
                    n_cmd   = i_q_cmd;
                    n_state = tccw_pkg::ST_EXEC;
                end
            end
            tccw_pkg::ST_EXEC: begin
                unique case (r_cmd.kind) inside
                    tccw_pkg::KIND_PUT, tccw_pkg::KIND_NEWLINE: begin
                        if (r_row == ROW_W'(ROWS)) begin
                            n_idx   = '0;
                            n_state = tccw_pkg::ST_SCROLL;
                        end else begin
                            if (r_cmd.kind == tccw_pkg::KIND_NEWLINE) begin
                                n_row = r_row + 1'b1;
                                n_col = '0;
                                n_lin = r_lin + CNT_W'(COLS) - CNT_W'(r_col);
                            end else begin
                                mem_we = 1'b1;
                                mem_wa = r_lin[ADDR_W-1:0];
                                mem_wd = {i_text_color, r_cmd.ch};
                                n_lin  = r_lin + 1'b1;
                                if (r_col == COL_W'(COLS - 1)) begin
                                    n_row = r_row + 1'b1;
                                    n_col = '0;
                                end else begin
                                    n_col = r_col + 1'b1;
                                end
                            end
                            n_out_valid = 1'b1;
                            n_out_pos   = tccw_pkg::POS_W'(n_lin);
                            n_out_cell  = '0;
                            n_state     = tccw_pkg::ST_IDLE;
                        end
                    end
                    tccw_pkg::KIND_CLEAR: begin
                        n_idx   = '0;
                        n_state = tccw_pkg::ST_CLEAR;
                    end
                    tccw_pkg::KIND_READ: begin
                        n_state = tccw_pkg::ST_READ;
                    end
                    default: begin
                        n_out_valid = 1'b1;
                        n_out_pos   = tccw_pkg::POS_W'(r_lin);
                        n_out_cell  = '0;
                        n_state     = tccw_pkg::ST_IDLE;
                    end
                endcase
            end
            tccw_pkg::ST_SCROLL: begin
                // Read the source cell one row down, write the previous one
                mem_ra = rd_src[ADDR_W-1:0];
                n_idx  = r_idx + 1'b1;
                if (r_idx != '0) begin
                    mem_we = 1'b1;
                    mem_wa = idx_m1[ADDR_W-1:0];
                    mem_wd = (idx_m1 < CNT_W'(MOVE)) ? r_rd_data : blank;
                end
                if (r_idx == CNT_W'(CELLS)) begin
                    n_idx   = '0;
                    n_row   = ROW_W'(ROWS - 1);
                    n_lin   = r_lin - CNT_W'(COLS);
                    n_state = tccw_pkg::ST_EXEC;
                end
            end
            tccw_pkg::ST_CLEAR: begin
                mem_we = 1'b1;
                n_idx  = r_idx + 1'b1;
                if (r_idx == CNT_W'(CELLS - 1)) begin
                    n_idx       = '0;
                    n_row       = '0;
                    n_col       = '0;
                    n_lin       = '0;
                    n_out_valid = 1'b1;
                    n_out_pos   = '0;
                    n_out_cell  = '0;
                    n_state     = tccw_pkg::ST_IDLE;
                end
            end
            tccw_pkg::ST_READ: begin
                n_out_valid = 1'b1;
                n_out_pos   = tccw_pkg::POS_W'(r_lin);
                n_out_cell  = r_rd_data;
                n_state     = tccw_pkg::ST_IDLE;
            end
            default: begin
                n_state = tccw_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tccw_pkg::ST_INIT;
            r_idx       <= '0;
            r_row       <= ROW_W'(2);
            r_col       <= '0;
            r_lin       <= CNT_W'(2 * COLS);
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_row       <= n_row;
            r_col       <= n_col;
            r_lin       <= n_lin;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd      <= n_cmd;
        r_out_pos  <= n_out_pos;
        r_out_cell <= n_out_cell;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rd_data <= mem[mem_ra];
    end

endmodule

// ===== rtl/text_console_char_writer.sv =====
// Top level of the text console character writer.
// Keeps a COLS x ROWS text screen of 16-bit cells (attribute in the high byte,
// character in the low byte) and a cursor; each input word yields exactly one
// result word carrying the linear cursor position and, for a read, the cell.
// After reset the block sweeps the whole screen to white-on-black blanks, one
// cell a cycle, and takes no input word until the sweep is done; the colour
// register may be written meanwhile. A front end decodes each word into a
// short queue, and a back end owning the screen memory (one write and one
// read port) carries it out. An ordinary put, newline or out-of-range read
// passes through IDLE and EXEC to the result; a valid read also passes
// through READ, since the memory read data is registered. A put or newline
// with the cursor one row past the bottom first scrolls, copying one cell a
// cycle; clear writes one cell a cycle. Until full, the queue keeps taking
// words while the back end is busy or the result word waits on m_axis_tready.
module text_console_char_writer #(
    parameter int COLS = 80,
    parameter int ROWS = 25
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input words
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // op[1:0], ch[9:2], read_addr[20:10], zero pad
    // Result words
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // cursor_pos[10:0], cell_data[26:11], zero pad
    // Colour register write
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data      // text_color
);

    logic [7:0]     r_text_color;
    logic           init_busy;
    logic           q_full;
    logic           q_empty;
    logic           q_push;
    logic           q_pop;
    tccw_pkg::t_cmd front_cmd;
    tccw_pkg::t_cmd head_cmd;
    logic [tccw_pkg::POS_W-1:0]  out_pos;
    logic [tccw_pkg::CELL_W-1:0] out_cell;

    // The colour register is always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_color <= tccw_pkg::RESET_COLOR;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_text_color <= i_cfg_data;
        end
    end

    // Decode the incoming word into a command
    tccw_front #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_front (
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_data      (s_axis_tdata),
        .i_init_busy (init_busy),
        .i_q_full    (q_full),
        .o_push      (q_push),
        .o_cmd       (front_cmd)
    );

    // Decouple decoding from execution
    tccw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_cmd   (head_cmd)
    );

    // Execute commands against the screen and cursor
    tccw_back #(
        .COLS (COLS),
        .ROWS (ROWS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_text_color (r_text_color),
        .i_q_empty    (q_empty),
        .i_q_cmd      (head_cmd),
        .o_pop        (q_pop),
        .o_init_busy  (init_busy),
        .o_valid      (m_axis_tvalid),
        .i_ready      (m_axis_tready),
        .o_cursor_pos (out_pos),
        .o_cell_data  (out_cell)
    );

    assign m_axis_tdata = {5'b0, out_cell, out_pos};

    // No word is taken while the screen sweep after reset runs
    a_no_accept_in_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        init_busy |-> !s_axis_tready)
        else $error("input word accepted during reset sweep");

    // An accepted word is held in the queue on the next cycle
    a_accept_queued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !q_empty)
        else $error("accepted word not queued");

    // The reset sweep produces no result word
    a_no_result_after_init: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $fell(init_busy) |-> !m_axis_tvalid)
        else $error("result word appeared during reset sweep");

endmodule
